[rtl/arqw_pkg.sv]
// ----------------------------------------------------------------------------
// arqw_pkg
// Types and constants shared by the ARQ sender window block.
// ----------------------------------------------------------------------------
package arqw_pkg;

  localparam int WINDOW_MAX_DEF = 32;
  localparam int SEQ_BITS_DEF   = 32;

  // Fixed field and register widths
  localparam int FIELD_W    = 32;
  localparam int WS_W       = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [WS_W-1:0]    WS_RESET    = 6'd16;
  localparam logic [FIELD_W-1:0] TOTAL_RESET = 32'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_SIZE   = 1'b0,
    CFG_TOTAL_PACKETS = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CMD_ACK  = 2'd0,
    CMD_NACK = 2'd1,
    CMD_TICK = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_SEND   = 2'd0,
    KIND_RESEND = 2'd1,
    KIND_DONE   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [FIELD_W-1:0] seq_number;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [FIELD_W-1:0] packet_seq;
    logic               last_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACK_CMP,
    ST_ACK_FIN,
    ST_ACK_INC,
    ST_NACK,
    ST_FILL,
    ST_SWEEP
  } state_t;

endpackage

[rtl/arqw_seq_unit.sv]
// ----------------------------------------------------------------------------
// arqw_seq_unit
// Shared sequence-number adder: add or subtract, with carry out (no borrow).
// ----------------------------------------------------------------------------
module arqw_seq_unit #(
  parameter int SEQ_BITS = arqw_pkg::SEQ_BITS_DEF
) (
  input  logic [SEQ_BITS-1:0] op_a,
  input  logic [SEQ_BITS-1:0] op_b,
  input  logic                sub,
  output logic [SEQ_BITS-1:0] sum,
  output logic                carry
);

  logic [SEQ_BITS-1:0] b_eff;
  logic [SEQ_BITS:0]   full;

  assign b_eff = sub ? ~op_b : op_b;
  assign full  = {1'b0, op_a} + {1'b0, b_eff} + {{SEQ_BITS{1'b0}}, sub};
  assign sum   = full[SEQ_BITS-1:0];
  // on subtract: set when op_a >= op_b
  assign carry = full[SEQ_BITS];

endmodule

[rtl/arqw_mark_mem.sv]
// ----------------------------------------------------------------------------
// arqw_mark_mem
// Resend marks, one bit per window slot; one write and one registered read.
// ----------------------------------------------------------------------------
module arqw_mark_mem #(
  parameter int AW = $clog2(arqw_pkg::WINDOW_MAX_DEF)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  localparam int DEPTH = 1 << AW;

  logic mark_mem_r [0:DEPTH-1];
  logic rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mark_mem_r[waddr] <= wdata;
    end
    rdata_r <= mark_mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/arq_sender_window.sv]
// ----------------------------------------------------------------------------
// arq_sender_window
// Sender side of a sliding-window ARQ with cumulative ACK and selective NACK.
// ----------------------------------------------------------------------------
// A command is taken when start is high, busy is low and no done has been sent;
// busy stays high until the command is finished. Results appear on out_data for
// one cycle each with out_valid high, and the receiver cannot stall them. Every
// command runs on one shared sequence-number adder under a small sequencer: a
// NACK runs its check state, an ACK a compare and a finish state plus an
// increment state when it drops only part of the window, and a timeout tick a
// fill state and then a sweep state, both of which use the adder once per entry;
// a tick that leaves the window empty sweeps no entries.
// The resend marks sit in a small memory indexed by the low sequence bits and
// need no clearing after reset.
// ----------------------------------------------------------------------------
module arq_sender_window #(
  parameter int WINDOW_MAX = arqw_pkg::WINDOW_MAX_DEF,
  parameter int SEQ_BITS   = arqw_pkg::SEQ_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  arqw_pkg::in_item_t                in_data,
  output logic                              out_valid,
  output arqw_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [arqw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [arqw_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import arqw_pkg::*;

  localparam int MARK_AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW      = $clog2(WINDOW_MAX + 1);
  localparam int CMPW    = (CW > WS_W) ? CW : WS_W;

  state_t                state_r, state_nxt;
  logic [WS_W-1:0]       window_size_r;
  logic [FIELD_W-1:0]    total_packets_r;
  logic [SEQ_BITS-1:0]   base_r, base_nxt;
  logic [SEQ_BITS-1:0]   next_r, next_nxt;
  logic [SEQ_BITS-1:0]   seq_r, seq_nxt;
  logic [CW-1:0]         occ_r, occ_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic                  final_known_r, final_known_nxt;
  logic                  done_r, done_nxt;
  logic                  partial_r, partial_nxt;
  logic                  fill_stop_r, fill_stop_nxt;
  logic                  s2_valid_r, s2_valid_nxt;
  logic [SEQ_BITS-1:0]   s2_seq_r, s2_seq_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  logic [SEQ_BITS-1:0]   pend_seq_r, pend_seq_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic [SEQ_BITS-1:0]   alu_a, alu_b, alu_sum;
  logic                  alu_sub, alu_carry;

  logic                  mark_we, mark_wdata, mark_rd;
  logic [MARK_AW-1:0]    mark_waddr, mark_raddr;

  logic [SEQ_BITS-1:0]   final_seq;
  logic [CW-1:0]         occ_m1;
  logic [CMPW-1:0]       ws_ext, ws_cap, occ_ext;

  arqw_seq_unit #(.SEQ_BITS(SEQ_BITS)) u_seq_unit (
    .op_a  (alu_a),
    .op_b  (alu_b),
    .sub   (alu_sub),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  arqw_mark_mem #(.AW(MARK_AW)) u_mark_mem (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (mark_raddr),
    .rdata (mark_rd)
  );

  assign final_seq = SEQ_BITS'(total_packets_r);
  assign occ_m1    = occ_r - CW'(1);
  assign ws_ext    = CMPW'(window_size_r);
  assign ws_cap    = (ws_ext > CMPW'(WINDOW_MAX)) ? CMPW'(WINDOW_MAX) : ws_ext;
  assign occ_ext   = CMPW'(occ_r);

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r   <= WS_RESET;
      total_packets_r <= TOTAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WINDOW_SIZE:   window_size_r   <= cfg_data[WS_W-1:0];
        CFG_TOTAL_PACKETS: total_packets_r <= cfg_data[FIELD_W-1:0];
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      base_r        <= SEQ_BITS'(1);
      next_r        <= SEQ_BITS'(1);
      occ_r         <= '0;
      idx_r         <= '0;
      final_known_r <= 1'b0;
      done_r        <= 1'b0;
      partial_r     <= 1'b0;
      fill_stop_r   <= 1'b0;
      s2_valid_r    <= 1'b0;
      pend_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      base_r        <= base_nxt;
      next_r        <= next_nxt;
      occ_r         <= occ_nxt;
      idx_r         <= idx_nxt;
      final_known_r <= final_known_nxt;
      done_r        <= done_nxt;
      partial_r     <= partial_nxt;
      fill_stop_r   <= fill_stop_nxt;
      s2_valid_r    <= s2_valid_nxt;
      pend_valid_r  <= pend_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    seq_r      <= seq_nxt;
    s2_seq_r   <= s2_seq_nxt;
    pend_seq_r <= pend_seq_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    base_nxt        = base_r;
    next_nxt        = next_r;
    seq_nxt         = seq_r;
    occ_nxt         = occ_r;
    idx_nxt         = idx_r;
    final_known_nxt = final_known_r;
    done_nxt        = done_r;
    partial_nxt     = partial_r;
    fill_stop_nxt   = fill_stop_r;
    s2_valid_nxt    = 1'b0;
    s2_seq_nxt      = s2_seq_r;
    pend_valid_nxt  = pend_valid_r;
    pend_seq_nxt    = pend_seq_r;
    out_valid_nxt   = 1'b0;
    out_data_nxt    = out_data_r;

    alu_a      = seq_r;
    alu_b      = base_r;
    alu_sub    = 1'b1;
    mark_we    = 1'b0;
    mark_waddr = seq_r[MARK_AW-1:0];
    mark_wdata = 1'b0;
    mark_raddr = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start && !done_r) begin
          seq_nxt = SEQ_BITS'(in_data.seq_number);
          case (in_data.command)
            CMD_ACK:  state_nxt = ST_ACK_CMP;
            CMD_NACK: state_nxt = ST_NACK;
            CMD_TICK: begin
              state_nxt     = ST_FILL;
              fill_stop_nxt = 1'b0;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      // seq - base: decide how much of the window the ack drops
      ST_ACK_CMP: begin
        partial_nxt = 1'b0;
        if (alu_carry && (occ_r != '0)) begin
          // an ack of the all-ones number also drops past the wrap
          if ((&seq_r) || (alu_sum >= SEQ_BITS'(occ_m1))) begin
            base_nxt = next_r;
            occ_nxt  = '0;
          end else begin
            partial_nxt = 1'b1;
            occ_nxt     = occ_r - (alu_sum[CW-1:0] + CW'(1));
          end
        end
        state_nxt = ST_ACK_FIN;
      end

      // seq - final: finish check
      ST_ACK_FIN: begin
        alu_b = final_seq;
        if (final_known_r && alu_carry) begin
          done_nxt                 = 1'b1;
          out_valid_nxt            = 1'b1;
          out_data_nxt.kind        = KIND_DONE;
          out_data_nxt.packet_seq  = total_packets_r;
          out_data_nxt.last_of_run = 1'b1;
        end
        state_nxt = partial_r ? ST_ACK_INC : ST_IDLE;
      end

      ST_ACK_INC: begin
        alu_b     = SEQ_BITS'(1);
        alu_sub   = 1'b0;
        base_nxt  = alu_sum;
        state_nxt = ST_IDLE;
      end

      ST_NACK: begin
        if (alu_sum < SEQ_BITS'(occ_r)) begin
          mark_we                  = 1'b1;
          mark_wdata               = 1'b1;
          out_valid_nxt            = 1'b1;
          out_data_nxt.kind        = KIND_RESEND;
          out_data_nxt.packet_seq  = FIELD_W'(seq_r);
          out_data_nxt.last_of_run = 1'b1;
        end
        state_nxt = ST_IDLE;
      end

      // one fresh entry per cycle
      ST_FILL: begin
        alu_a      = next_r;
        alu_b      = SEQ_BITS'(1);
        alu_sub    = 1'b0;
        mark_waddr = next_r[MARK_AW-1:0];
        if (!final_known_r && !fill_stop_r && (occ_ext < ws_cap)) begin
          mark_we       = 1'b1;
          next_nxt      = alu_sum;
          occ_nxt       = occ_r + CW'(1);
          fill_stop_nxt = (next_r == final_seq);
        end else begin
          state_nxt      = ST_SWEEP;
          idx_nxt        = '0;
          pend_valid_nxt = 1'b0;
        end
      end

      // front: base + idx and mark read; back: mark test, clear, emit.
      // A found entry is held until the next one is found so the last transfer can be flagged.
      ST_SWEEP: begin
        alu_a   = base_r;
        alu_b   = SEQ_BITS'(idx_r);
        alu_sub = 1'b0;
        if (idx_r < occ_r) begin
          mark_raddr   = alu_sum[MARK_AW-1:0];
          s2_valid_nxt = 1'b1;
          s2_seq_nxt   = alu_sum;
          idx_nxt      = idx_r + CW'(1);
        end
        if (s2_valid_r) begin
          mark_we    = 1'b1;
          mark_waddr = s2_seq_r[MARK_AW-1:0];
          if (s2_seq_r == final_seq) begin
            final_known_nxt = 1'b1;
          end
          if (!mark_rd) begin
            if (pend_valid_r) begin
              out_valid_nxt            = 1'b1;
              out_data_nxt.kind        = KIND_SEND;
              out_data_nxt.packet_seq  = FIELD_W'(pend_seq_r);
              out_data_nxt.last_of_run = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_seq_nxt   = s2_seq_r;
          end
        end else if (idx_r >= occ_r) begin
          if (pend_valid_r) begin
            out_valid_nxt            = 1'b1;
            out_data_nxt.kind        = KIND_SEND;
            out_data_nxt.packet_seq  = FIELD_W'(pend_seq_r);
            out_data_nxt.last_of_run = 1'b1;
          end
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
